>>> rtl/core/tbc_pkg.sv
// Package: shared constants and types of the tagged block cache.
package tbc_pkg;
    localparam int LINES       = 64;
    localparam int BLOCK_WORDS = 32;
    localparam int LINE_W      = $clog2(LINES);
    localparam int WORD_W      = $clog2(BLOCK_WORDS);
    localparam int DATA_DEPTH  = LINES * BLOCK_WORDS;
    localparam int DADDR_W     = $clog2(DATA_DEPTH);
    localparam int TAG_W       = 40;
    localparam int STAMP_W     = 16;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 7;
    localparam int CFG_RESET   = 64;
    localparam int META_W      = TAG_W + STAMP_W;

    localparam logic [1:0] ST_MISS = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_PUT  = 2'd2;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic [1:0]        status;
        logic [63:0]       read_word;
        logic [WORD_W-1:0] word_pos;
        logic              last;
    } result_t;
endpackage

>>> rtl/core/tbc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module tbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/tagged_block_cache_lru_top.sv
// Top level: fully associative LRU block cache with stream ports.
// A get walks the active lines one per cycle through the tag/stamp memory,
// then a hit streams BLOCK_WORDS beats from the data memory at one beat per
// cycle while the receiver is ready; a miss gives one beat. A put word with
// word_index zero walks the lines the same way to pick a victim (first empty
// line, else oldest stamp); other put words go straight to the write.
// Writing lines_in_use empties the cache and clears the counters at once.
module tagged_block_cache_lru_top (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [tbc_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // tdata: device_id[7:0], sector[23:8], block_num[39:24], word_index[44:40],
    //        write_word[108:45], zero fill to 112
    input  logic [111:0]            s_tdata,
    // tuser: operation
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // tdata: status[1:0], read_word[65:2], word_pos[70:66], hit_total[102:71],
    //        miss_total[134:103], zero fill to 136
    output logic [135:0]            m_tdata,
    output logic                    m_tlast
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_STREAM = 3'd3;

    localparam int LC_W = tbc_pkg::LINE_W + 1;

    logic [2:0] state_reg, state_next;
    logic [tbc_pkg::LINES-1:0] valid_reg;
    logic [tbc_pkg::STAMP_W-1:0] stamp_cnt_reg;
    logic [tbc_pkg::LINE_W-1:0] fill_line_reg;
    logic [tbc_pkg::CNT_W-1:0] hit_reg, miss_reg;
    logic [LC_W-1:0] active_reg;

    logic op_reg;
    logic [tbc_pkg::TAG_W-1:0] tag_reg;
    logic [tbc_pkg::WORD_W-1:0] widx_reg;
    logic [63:0] wword_reg;
    logic [LC_W-1:0] scan_reg;
    logic rd_pend_reg;
    logic [tbc_pkg::LINE_W-1:0] rd_line_reg;
    logic found_reg;
    logic [tbc_pkg::LINE_W-1:0] pick_reg;
    logic [tbc_pkg::STAMP_W-1:0] best_reg;
    logic [tbc_pkg::WORD_W:0] wcnt_reg;
    logic dpend_reg;
    logic [tbc_pkg::WORD_W-1:0] dpos_reg;

    logic out_v_reg;
    tbc_pkg::result_t out_reg;

    logic [tbc_pkg::META_W-1:0] meta_rdata, meta_wdata;
    logic meta_we;
    logic [tbc_pkg::LINE_W-1:0] meta_waddr, meta_raddr;
    logic [63:0] data_rdata;
    logic data_we;
    logic [tbc_pkg::DADDR_W-1:0] data_waddr, data_raddr;

    logic [tbc_pkg::LINE_W-1:0] s_dev_line;
    logic [tbc_pkg::WORD_W-1:0] s_widx;
    logic s_acc, m_acc, out_free, out_load;
    logic [tbc_pkg::STAMP_W-1:0] age;
    logic [tbc_pkg::TAG_W-1:0] rd_tag;
    logic [tbc_pkg::STAMP_W-1:0] rd_stamp;
    logic cand_inv, cand_hit;
    logic put_word_now;

    assign s_widx = s_tdata[44:40];
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign out_free = !out_v_reg || m_tready;
    assign out_load = out_free && (((state_reg == S_DECIDE)
                      && !(op_reg == tbc_pkg::OP_GET && found_reg))
                      || ((state_reg == S_STREAM) && dpend_reg));
    assign s_tready = (state_reg == S_IDLE) && !cfg_wen;
    assign s_dev_line = fill_line_reg;

    assign rd_tag = meta_rdata[tbc_pkg::META_W-1:tbc_pkg::STAMP_W];
    assign rd_stamp = meta_rdata[tbc_pkg::STAMP_W-1:0];
    assign age = stamp_cnt_reg - rd_stamp;
    assign cand_inv = !valid_reg[rd_line_reg];
    assign cand_hit = valid_reg[rd_line_reg] && (rd_tag == tag_reg);

    assign meta_raddr = scan_reg[tbc_pkg::LINE_W-1:0];
    assign data_raddr = {pick_reg, ((state_reg == S_STREAM) && !out_free) ? dpos_reg
                                   : wcnt_reg[tbc_pkg::WORD_W-1:0]};

    tbc_ram #(.WIDTH(tbc_pkg::META_W), .DEPTH(tbc_pkg::LINES)) u_meta (
        .aclk(aclk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rdata)
    );

    tbc_ram #(.WIDTH(64), .DEPTH(tbc_pkg::DATA_DEPTH)) u_data (
        .aclk(aclk), .we(data_we), .waddr(data_waddr), .wdata(wword_reg),
        .raddr(data_raddr), .rdata(data_rdata)
    );

    assign put_word_now = (state_reg == S_DECIDE) && (op_reg == tbc_pkg::OP_PUT);

    always_comb begin
        state_next = state_reg;
        meta_we = 1'b0;
        meta_waddr = pick_reg;
        meta_wdata = {tag_reg, stamp_cnt_reg};
        data_we = 1'b0;
        data_waddr = {fill_line_reg, widx_reg};
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == tbc_pkg::OP_PUT && s_widx != '0) begin
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!rd_pend_reg && scan_reg >= active_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    if (op_reg == tbc_pkg::OP_GET) begin
                        if (found_reg) begin
                            meta_we = 1'b1;
                            state_next = S_STREAM;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        if (widx_reg == '0) begin
                            meta_we = 1'b1;
                        end
                        data_we = 1'b1;
                        if (widx_reg == '0) begin
                            data_waddr = {pick_reg, widx_reg};
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_STREAM: begin
                if (wcnt_reg == (tbc_pkg::WORD_W+1)'(tbc_pkg::BLOCK_WORDS) && !dpend_reg
                    && out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            stamp_cnt_reg <= '0;
            fill_line_reg <= '0;
            hit_reg <= '0;
            miss_reg <= '0;
            active_reg <= LC_W'(tbc_pkg::CFG_RESET);
            out_v_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            dpend_reg <= 1'b0;
        end else if (cfg_wen) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            stamp_cnt_reg <= '0;
            fill_line_reg <= '0;
            hit_reg <= '0;
            miss_reg <= '0;
            if (cfg_wdata == '0) begin
                active_reg <= LC_W'(1);
            end else if (32'(cfg_wdata) > tbc_pkg::LINES) begin
                active_reg <= LC_W'(tbc_pkg::LINES);
            end else begin
                active_reg <= LC_W'(cfg_wdata);
            end
            rd_pend_reg <= 1'b0;
            dpend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_v_reg <= 1'b1;
            end else if (m_acc) begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    rd_pend_reg <= 1'b0;
                end
                S_SCAN: begin
                    rd_pend_reg <= (scan_reg < active_reg);
                    if (scan_reg < active_reg) begin
                        scan_reg <= scan_reg + LC_W'(1);
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        out_reg.read_word <= '0;
                        out_reg.last <= 1'b1;
                        if (op_reg == tbc_pkg::OP_GET) begin
                            if (found_reg) begin
                                stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                                if (hit_reg != '1) hit_reg <= hit_reg + 1'b1;
                                wcnt_reg <= '0;
                                dpend_reg <= 1'b0;
                            end else begin
                                if (miss_reg != '1) miss_reg <= miss_reg + 1'b1;
                                out_reg.status <= tbc_pkg::ST_MISS;
                                out_reg.word_pos <= '0;
                            end
                        end else begin
                            if (widx_reg == '0) begin
                                valid_reg[pick_reg] <= 1'b1;
                                stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                                fill_line_reg <= pick_reg;
                            end
                            out_reg.status <= tbc_pkg::ST_PUT;
                            out_reg.word_pos <= widx_reg;
                        end
                    end
                end
                S_STREAM: begin
                    if (out_free) begin
                        if (dpend_reg) begin
                            out_reg.status <= tbc_pkg::ST_HIT;
                            out_reg.read_word <= data_rdata;
                            out_reg.word_pos <= dpos_reg;
                            out_reg.last <= (32'(dpos_reg) == tbc_pkg::BLOCK_WORDS - 1);
                        end
                        dpend_reg <= (wcnt_reg != (tbc_pkg::WORD_W+1)'(tbc_pkg::BLOCK_WORDS));
                        dpos_reg <= wcnt_reg[tbc_pkg::WORD_W-1:0];
                        if (wcnt_reg != (tbc_pkg::WORD_W+1)'(tbc_pkg::BLOCK_WORDS)) begin
                            wcnt_reg <= wcnt_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (s_acc) begin
            op_reg <= s_tuser;
            tag_reg <= {s_tdata[7:0], s_tdata[23:8], s_tdata[39:24]};
            widx_reg <= s_widx;
            wword_reg <= s_tdata[108:45];
            scan_reg <= '0;
            found_reg <= 1'b0;
            pick_reg <= s_dev_line;
            best_reg <= '0;
        end else if (state_reg == S_SCAN) begin
            rd_line_reg <= meta_raddr;
            if (rd_pend_reg && !found_reg) begin
                if (op_reg == tbc_pkg::OP_GET) begin
                    if (cand_hit) begin
                        found_reg <= 1'b1;
                        pick_reg <= rd_line_reg;
                    end
                end else if (cand_inv) begin
                    found_reg <= 1'b1;
                    pick_reg <= rd_line_reg;
                end else if (rd_line_reg == '0 || age > best_reg) begin
                    best_reg <= age;
                    pick_reg <= rd_line_reg;
                end
            end
        end
        if (put_word_now && widx_reg != '0) begin
            pick_reg <= fill_line_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast = out_reg.last;
    assign m_tdata = {1'b0, miss_reg, hit_reg, out_reg.word_pos, out_reg.read_word,
                      out_reg.status};
endmodule

>>> rtl/core/tbc_checker.sv
// Checker: port-level assertions of the block cache, bound to the top level.
module tbc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         cfg_wen,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn || cfg_wen)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled beat changed");
    a_miss_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == tbc_pkg::ST_MISS |-> m_tlast)
        else $error("miss beat without tlast");
    a_put_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == tbc_pkg::ST_PUT |-> m_tdata[65:2] == '0 && m_tlast)
        else $error("put beat malformed");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] == tbc_pkg::ST_MISS || m_tdata[1:0] == tbc_pkg::ST_HIT
                     || m_tdata[1:0] == tbc_pkg::ST_PUT)
        else $error("bad status");
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !cfg_wen)
        else $error("beat accepted during register write");
endmodule

bind tagged_block_cache_lru_top tbc_checker u_tbc_checker (
    .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .s_tvalid(s_tvalid),
    .s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

>>> tb/testbench.sv
// Testbench for the tagged LRU block cache: stream driver, monitor and predictor.
`timescale 1ns / 100ps
module testbench;
    typedef struct packed {
        logic        op;
        logic [7:0]  dev;
        logic [15:0] sec;
        logic [15:0] blk;
        logic [4:0]  widx;
        logic [63:0] wdata;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] word;
        logic [4:0]  pos;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
    } resp_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wen;
    logic [6:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tlast;

    tagged_block_cache_lru_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // cache shadow
    logic        sh_valid [tbc_pkg::LINES];
    logic [39:0] sh_tag   [tbc_pkg::LINES];
    logic [15:0] sh_stamp [tbc_pkg::LINES];
    logic [63:0] sh_data  [tbc_pkg::LINES][tbc_pkg::BLOCK_WORDS];
    logic [15:0] sh_clock;
    int          sh_fill;
    logic [31:0] sh_hits;
    logic [31:0] sh_misses;
    int          sh_active;

    req_t   pending_beats[$];
    resp_t  expected_beats[$];
    int     errors;
    int     sent_count;
    int     got_count;
    int     hit_blocks;
    int     victim_evicts;
    longint cycles;
    logic   hold_off;
    int     hold_cnt;
    bit     stall_start;
    bit     driving;
    bit     ready_en;
    int     gap_left;
    int     rx_gap;

    // generator-side view of filled tags, so gets may target fully written lines
    logic [39:0] known_tags[$];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void shadow_clear(int n);
        for (int i = 0; i < tbc_pkg::LINES; i++) sh_valid[i] = 1'b0;
        sh_clock = '0;
        sh_fill = 0;
        sh_hits = '0;
        sh_misses = '0;
        sh_active = (n < 1) ? 1 : (n > tbc_pkg::LINES ? tbc_pkg::LINES : n);
    endfunction

    function automatic void predict_cache(req_t r);
        logic [39:0] tag;
        int          hit_line;
        int          v;
        logic [15:0] best;
        logic [15:0] age;
        bit          found;
        resp_t       e;
        tag = {r.dev, r.sec, r.blk};
        if (r.op == tbc_pkg::OP_GET) begin
            hit_line = -1;
            for (int i = 0; i < sh_active; i++)
                if (hit_line < 0 && sh_valid[i] && sh_tag[i] == tag) hit_line = i;
            if (hit_line < 0) begin
                if (sh_misses != 32'hFFFF_FFFF) sh_misses++;
                e = '{tbc_pkg::ST_MISS, 64'd0, 5'd0, 1'b1, sh_hits, sh_misses};
                expected_beats.push_back(e);
            end else begin
                sh_stamp[hit_line] = sh_clock;
                sh_clock++;
                if (sh_hits != 32'hFFFF_FFFF) sh_hits++;
                hit_blocks++;
                for (int w = 0; w < tbc_pkg::BLOCK_WORDS; w++) begin
                    e = '{tbc_pkg::ST_HIT, sh_data[hit_line][w], 5'(w),
                          w == tbc_pkg::BLOCK_WORDS - 1, sh_hits, sh_misses};
                    expected_beats.push_back(e);
                end
            end
        end else begin
            if (r.widx == 0) begin
                found = 1'b0;
                v = 0;
                for (int i = 0; i < sh_active; i++)
                    if (!found && !sh_valid[i]) begin
                        v = i;
                        found = 1'b1;
                    end
                if (!found) begin
                    victim_evicts++;
                    best = sh_clock - sh_stamp[0];
                    for (int i = 1; i < sh_active; i++) begin
                        age = sh_clock - sh_stamp[i];
                        if (age > best) begin
                            best = age;
                            v = i;
                        end
                    end
                end
                sh_valid[v] = 1'b1;
                sh_tag[v] = tag;
                sh_stamp[v] = sh_clock;
                sh_clock++;
                sh_fill = v;
            end
            sh_data[sh_fill][r.widx] = r.wdata;
            e = '{tbc_pkg::ST_PUT, 64'd0, r.widx, 1'b1, sh_hits, sh_misses};
            expected_beats.push_back(e);
        end
    endfunction

    // a full block write, so later hits never read unwritten words
    task automatic queue_block(logic [39:0] tag, bit rand_data);
        req_t r;
        for (int w = 0; w < tbc_pkg::BLOCK_WORDS; w++) begin
            r.op = tbc_pkg::OP_PUT;
            {r.dev, r.sec, r.blk} = (w == 0) ? tag : 40'({$urandom, $urandom});
            r.widx = 5'(w);
            r.wdata = rand_data ? {$urandom, $urandom} : (w[0] ? '1 : '0);
            pending_beats.push_back(r);
        end
        known_tags.push_back(tag);
    endtask

    task automatic queue_get(logic [39:0] tag);
        req_t r;
        r = '{tbc_pkg::OP_GET, tag[39:32], tag[31:16], tag[15:0], 5'($urandom),
              {$urandom, $urandom}};
        pending_beats.push_back(r);
    endtask

    function automatic logic [39:0] pick_tag();
        if (known_tags.size() > 0 && $urandom_range(0, 9) < 8)
            return known_tags[$urandom_range(0, known_tags.size() - 1)];
        return {8'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 16'($urandom_range(0, 7))};
    endfunction

    task automatic drain_and_write(int n);
        while (pending_beats.size() > 0 || driving || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (tbc_pkg::LINES + tbc_pkg::BLOCK_WORDS + 10) @(posedge aclk);
        cfg_wdata <= 7'(n);
        cfg_wen <= 1'b1;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        shadow_clear(n);
        known_tags.delete();
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            driving <= 1'b0;
            gap_left <= 0;
        end else begin
            req_t r;
            if (s_tvalid && s_tready) begin
                sent_count++;
                r = '{s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24],
                      s_tdata[44:40], s_tdata[108:45]};
                predict_cache(r);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                    driving <= 1'b0;
                end else if (pending_beats.size() > 0 && $urandom_range(0, 9) < 7) begin
                    r = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.op;
                    s_tdata <= {3'b0, r.wdata, r.widx, r.blk, r.sec, r.dev};
                    driving <= 1'b1;
                    if ($urandom_range(0, 49) == 0) gap_left <= $urandom_range(20, 60);
                end else begin
                    s_tvalid <= 1'b0;
                    driving <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            resp_t a, e;
            a = '{m_tdata[1:0], m_tdata[65:2], m_tdata[70:66], m_tlast,
                  m_tdata[102:71], m_tdata[134:103]};
            got_count++;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat %h", $realtime, a);
            end else begin
                e = expected_beats.pop_front();
                if (a !== e) begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $realtime, e, a);
                end
            end
        end
    end

    // long receiver hold-off
    assign hold_off = (hold_cnt != 0);

    always @(posedge aclk) begin
        if (!aresetn) hold_cnt <= 0;
        else if (stall_start) hold_cnt <= 400;
        else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap <= 0;
        end else if (hold_off || !ready_en) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if ($urandom_range(0, 199) == 0) begin
            m_tready <= 1'b0;
            rx_gap <= $urandom_range(20, 60);
        end else if ($urandom_range(0, 19) == 0) begin
            m_tready <= 1'b0;
        end else if (m_tready == 1'b0 && $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 2_000_000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [39:0] t;
        int          settings[4];
        errors = 0; sent_count = 0; got_count = 0; hit_blocks = 0; victim_evicts = 0;
        cycles = 0; stall_start = 1'b0; ready_en = 1'b0;
        aresetn = 1'b0; cfg_wen = 1'b0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
        shadow_clear(tbc_pkg::CFG_RESET);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        ready_en <= 1'b1;

        // directed: extremes, miss, hit, a stray put word before any word zero
        pending_beats.push_back(req_t'{tbc_pkg::OP_PUT, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd31,
                                       64'hFFFF_FFFF_FFFF_FFFF});
        queue_get(40'hFF_FFFF_FFFF);
        queue_block(40'hFF_FFFF_FFFF, 1'b0);
        queue_block(40'h00_0000_0000, 1'b0);
        queue_get(40'hFF_FFFF_FFFF);
        queue_get(40'h00_0000_0000);
        queue_get(40'h12_3456_789A);
        drain_and_write(0);
        // one active line: each word-zero put after the first evicts
        queue_block(40'h01_0001_0001, 1'b1);
        queue_block(40'h02_0002_0002, 1'b1);
        queue_get(40'h01_0001_0001);
        queue_get(40'h02_0002_0002);

        settings = '{2, 127, 4, 64};
        foreach (settings[p]) begin
            drain_and_write(settings[p]);
            if (p == 1) begin
                // stall the receiver while the sender keeps offering
                queue_block(40'h05_0005_0005, 1'b1);
                for (int k = 0; k < 6; k++) queue_get(40'h05_0005_0005);
                stall_start <= 1'b1;
                @(posedge aclk);
                stall_start <= 1'b0;
                @(posedge aclk);
                while (hold_off) @(posedge aclk);
            end
            for (int k = 0; k < 6; k++) begin
                t = pick_tag();
                case ($urandom_range(0, 9))
                    0, 1, 2: queue_block(t, 1'b1);
                    3: pending_beats.push_back(req_t'{tbc_pkg::OP_PUT, 8'($urandom),
                        16'($urandom), 16'($urandom), 5'($urandom_range(1, 31)),
                        {$urandom, $urandom}});
                    default: queue_get(t);
                endcase
            end
        end

        drain_and_write(64);
        while (pending_beats.size() > 0 || driving || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (tbc_pkg::LINES + tbc_pkg::BLOCK_WORDS + 10) @(posedge aclk);
        $display("Sent %0d beats, checked %0d result beats", sent_count, got_count);
        $display("Hit blocks %0d, LRU evictions %0d", hit_blocks, victim_evicts);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
